// ===== sv/lzrle_pkg.sv =====
// Shared types and constants for the LZ/RLE decompressor core.
// Token codes, result limits and the control structs between sequencer and packer.
// No dependencies.
package lzrle_pkg;

   // Token opening bytes.
   localparam logic [7:0] TOK_COPY = 8'hFF;
   localparam logic [7:0] TOK_RUN  = 8'hFE;
   localparam logic [7:0] TOK_ESC  = 8'hFD;

   // Stream header length and the widest token in bytes.
   localparam int HDR_BYTES = 4;
   localparam int TOK_BYTES = 4;

   // Most result words sent for one compressed word.
   localparam int MAX_RESULTS = 32;
   localparam int RES_W       = $clog2(MAX_RESULTS);

   // Requests from the sequencer to the output packer.
   typedef struct packed {
      logic       emit;
      logic [7:0] data;
      logic       flush;
      logic       stream_last;
   } pack_ctl_type;

   // Status from the output packer back to the sequencer.
   typedef struct packed {
      logic byte_ok;
      logic flush_ok;
   } pack_sts_type;

   // Number of bytes that a token opened by this byte occupies.
   function automatic logic [2:0] token_need(input logic [7:0] t);
      logic [2:0] need;
      case (t)
         TOK_COPY: need = 3'd4;
         TOK_RUN:  need = 3'd3;
         TOK_ESC:  need = 3'd2;
         default:  need = 3'd1;
      endcase
      return need;
   endfunction

endpackage

// ===== sv/lz_rle_decompressor_core.sv =====
// LZ/RLE decompressor core over lzrle_pkg, lzrle_hist_ram and lzrle_out_pack.
// A copy reads the history before the write. Run and copy expansion give one decoded byte a
// cycle from the single history write port while the result side does not stall; a new
// compressed word is taken only once the previous one has been expanded and flushed.
// Reset (synchronous, active high) clears the stream state; history content is not cleared.
module lz_rle_decompressor_core #(
   parameter int WINDOW_BYTES = 65536,
   parameter int OUT_LANES    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_token_last,
   output logic        rsp_stream_end
);

   localparam int AW = $clog2(WINDOW_BYTES);
   localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_BYTES - 1);
   localparam logic [AW:0]   WIN_EXT  = (AW+1)'(WINDOW_BYTES);
   localparam logic [2:0]    HDR_CNT  = 3'(lzrle_pkg::HDR_BYTES);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PARSE  = 5'b00010,
      S_RUN    = 5'b00100,
      S_COPY   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [31:0]   target_ff, target_in;
   logic [31:0]   produced_ff, produced_in;
   logic [2:0]    hdr_ff, hdr_in;
   logic [31:0]   tok_ff, tok_in;
   logic [2:0]    tok_n_ff, tok_n_in;
   logic          last_ff, last_in;
   logic [7:0]    run_byte_ff, run_byte_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [7:0]    rd_left_ff, rd_left_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          rd_vld_ff, rd_vld_in;

   logic [7:0]    tok0, tok1, tok2, tok3;
   logic [2:0]    need, sh;
   logic          tok_complete, room_ok, off_ok;
   logic [15:0]   off;
   logic [31:0]   left;
   logic [7:0]    span;
   logic [AW:0]   wr_ext, off_ext, start_ext;
   logic          emit_req, emit_ok, emitted, shift_en, consume, rd_en;
   logic [7:0]    emit_data, rd_data;

   lzrle_pkg::pack_ctl_type pack_ctl;
   lzrle_pkg::pack_sts_type pack_sts;

   // Token buffer view: pending bytes of an unfinished token plus the new word.
   assign tok0         = tok_ff[7:0];
   assign tok1         = tok_ff[15:8];
   assign tok2         = tok_ff[23:16];
   assign tok3         = tok_ff[31:24];
   assign need         = lzrle_pkg::token_need(tok0);
   assign tok_complete = (tok_n_ff >= need);
   assign sh           = tok_complete ? need : 3'd1;
   assign room_ok      = (produced_ff < target_ff);

   // Copy and run length, clipped to the bytes still owed by the header size.
   assign left = target_ff - produced_ff;
   assign span = (left < {24'd0, tok1}) ? left[7:0] : tok1;

   // Copy offset check and source address inside the circular history.
   assign off       = {tok2, tok3};
   assign off_ok    = (off != 16'd0) && ({16'd0, off} <= produced_ff);
   assign wr_ext    = {1'b0, wr_ptr_ff};
   assign off_ext   = (AW+1)'(off);
   assign start_ext = (off_ext <= wr_ext) ? (wr_ext - off_ext) : (wr_ext + WIN_EXT - off_ext);

   assign emit_ok = pack_sts.byte_ok;
   assign emitted = emit_req && emit_ok;
   assign consume = rd_vld_ff && emit_ok;
   assign rd_en   = (state_ff == S_COPY) && (rd_left_ff != 8'd0) && (!rd_vld_ff || consume);

   assign rd_vld_in = rd_en || (rd_vld_ff && !consume);
   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: header capture, token parse, run and copy expansion, step close.
   always_comb begin
      state_in    = state_ff;
      target_in   = target_ff;
      produced_in = produced_ff;
      hdr_in      = hdr_ff;
      tok_in      = tok_ff;
      tok_n_in    = tok_n_ff;
      last_in     = last_ff;
      run_byte_in = run_byte_ff;
      cnt_in      = cnt_ff;
      rd_left_in  = rd_left_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      emit_req    = 1'b0;
      emit_data   = tok0;
      shift_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_last_byte;
               if (hdr_ff < HDR_CNT) begin
                  target_in = {target_ff[23:0], req_in_byte};
                  hdr_in    = hdr_ff + 3'd1;
                  state_in  = S_FINISH;
               end else if (room_ok) begin
                  tok_in[{tok_n_ff[1:0], 3'b000} +: 8] = req_in_byte;
                  tok_n_in = tok_n_ff + 3'd1;
                  state_in = S_PARSE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_PARSE: begin
            if (!room_ok || (tok_n_ff == 3'd0)) begin
               // Nothing left to parse or size reached: held bytes are dropped.
               tok_n_in = 3'd0;
               state_in = S_FINISH;
            end else if (tok_complete) begin
               case (tok0)
                  lzrle_pkg::TOK_COPY: begin
                     shift_en = 1'b1;
                     if (off_ok && (span != 8'd0)) begin
                        rd_ptr_in  = start_ext[AW-1:0];
                        rd_left_in = span;
                        cnt_in     = span;
                        state_in   = S_COPY;
                     end
                  end
                  lzrle_pkg::TOK_RUN: begin
                     shift_en    = 1'b1;
                     run_byte_in = tok2;
                     cnt_in      = span;
                     if (span != 8'd0) begin
                        state_in = S_RUN;
                     end
                  end
                  lzrle_pkg::TOK_ESC: begin
                     emit_req  = 1'b1;
                     emit_data = tok1;
                     shift_en  = emit_ok;
                  end
                  default: begin
                     emit_req  = 1'b1;
                     emit_data = tok0;
                     shift_en  = emit_ok;
                  end
               endcase
            end else if (last_ff) begin
               // Stream ends inside a token: its opening byte becomes a literal.
               emit_req  = 1'b1;
               emit_data = tok0;
               shift_en  = emit_ok;
            end else begin
               // Token still incomplete: keep it pending for the next word.
               state_in = S_FINISH;
            end
         end

         S_RUN: begin
            emit_req  = 1'b1;
            emit_data = run_byte_ff;
            if (emit_ok) begin
               cnt_in = cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  state_in = S_PARSE;
               end
            end
         end

         S_COPY: begin
            emit_req  = rd_vld_ff;
            emit_data = rd_data;
            if (rd_en) begin
               rd_ptr_in  = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
               rd_left_in = rd_left_ff - 8'd1;
            end
            if (consume) begin
               cnt_in = cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  state_in = S_PARSE;
               end
            end
         end

         S_FINISH: begin
            if (pack_sts.flush_ok) begin
               state_in = S_IDLE;
               if (last_ff) begin
                  // End of stream: the next word starts a new header.
                  target_in   = 32'd0;
                  produced_in = 32'd0;
                  hdr_in      = 3'd0;
                  tok_in      = 32'd0;
                  tok_n_in    = 3'd0;
                  wr_ptr_in   = '0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Consume the parsed token bytes.
      if (shift_en) begin
         tok_in   = tok_ff >> {sh, 3'b000};
         tok_n_in = tok_n_ff - sh;
      end

      // Every decoded byte advances the history write pointer.
      if (emitted) begin
         produced_in = produced_ff + 32'd1;
         wr_ptr_in   = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         target_ff   <= 32'd0;
         produced_ff <= 32'd0;
         hdr_ff      <= 3'd0;
         tok_ff      <= 32'd0;
         tok_n_ff    <= 3'd0;
         last_ff     <= 1'b0;
         cnt_ff      <= 8'd0;
         rd_left_ff  <= 8'd0;
         rd_vld_ff   <= 1'b0;
         wr_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         target_ff   <= target_in;
         produced_ff <= produced_in;
         hdr_ff      <= hdr_in;
         tok_ff      <= tok_in;
         tok_n_ff    <= tok_n_in;
         last_ff     <= last_in;
         cnt_ff      <= cnt_in;
         rd_left_ff  <= rd_left_in;
         rd_vld_ff   <= rd_vld_in;
         wr_ptr_ff   <= wr_ptr_in;
      end
   end

   // Payload registers of the sequencer.
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      rd_ptr_ff   <= rd_ptr_in;
   end

   // History memory.
   lzrle_hist_ram #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .AW           (AW)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (emitted),
      .wr_addr (wr_ptr_ff),
      .wr_data (emit_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Output packer and result register.
   assign pack_ctl.emit        = emit_req;
   assign pack_ctl.data        = emit_data;
   assign pack_ctl.flush       = (state_ff == S_FINISH);
   assign pack_ctl.stream_last = last_ff;

   lzrle_out_pack #(
      .OUT_LANES (OUT_LANES)
   ) u_pack (
      .clock          (clock),
      .reset          (reset),
      .ctl            (pack_ctl),
      .sts            (pack_sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_token_last (rsp_token_last),
      .rsp_stream_end (rsp_stream_end)
   );

   // A history read is only in flight while a copy is running.
   a_rd_in_copy: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_COPY))
      else $error("history read pending outside copy");

   // Decoding never passes the size given in the header.
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= target_ff)
      else $error("decoded byte count beyond stream size");

   // Run and copy expansion always owe at least one byte.
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RUN) || (state_ff == S_COPY)) |-> (cnt_ff != 8'd0))
      else $error("expansion running with zero bytes left");

   // An empty word is only the end-of-stream marker.
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_count == 4'd0)) |-> (rsp_token_last && rsp_stream_end))
      else $error("empty result word that is not an end marker");

   // Stream end is always carried on the last word of a step.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_end) |-> rsp_token_last)
      else $error("stream end without token last");

endmodule

// ===== sv/lzrle_hist_ram.sv =====
// History memory of the decompressor: one write port and one registered read port.
// A read that hits the address written in the same cycle returns the new byte.
// Depends on nothing but its parameters.
module lzrle_hist_ram #(
   parameter int WINDOW_BYTES = 65536,
   parameter int AW           = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [WINDOW_BYTES];
   logic [7:0] q_ff;
   logic [7:0] fwd_data_ff;
   logic       fwd_sel_ff;

   // Storage write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; the array returns the old byte on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // Remember when the read collided with a write so the new byte is used.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_sel_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_data_ff : q_ff;

endmodule

// ===== sv/lzrle_out_pack.sv =====
// Output packer: gathers decoded bytes into words of up to OUT_LANES bytes and
// holds the result register toward the rsp_ channel.
// Depends on lzrle_pkg.
module lzrle_out_pack #(
   parameter int OUT_LANES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lzrle_pkg::pack_ctl_type ctl,
   output lzrle_pkg::pack_sts_type sts,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_out_bytes,
   output logic [3:0]              rsp_byte_count,
   output logic                    rsp_token_last,
   output logic                    rsp_stream_end
);

   localparam logic [3:0] FULL_CNT = 4'(OUT_LANES);
   localparam logic [lzrle_pkg::RES_W-1:0] LAST_RES =
      lzrle_pkg::RES_W'(lzrle_pkg::MAX_RESULTS - 1);

   logic [63:0]                  pack_ff, pack_in;
   logic [3:0]                   pack_cnt_ff, pack_cnt_in;
   logic [lzrle_pkg::RES_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                         muted_ff, muted_in;
   logic                         out_vld_ff, out_vld_in;
   logic [63:0]                  out_bytes_ff;
   logic [3:0]                   out_cnt_ff;
   logic                         out_last_ff, out_end_ff;
   logic                         push_ok, pack_full, flush_need, do_emit, do_flush;
   logic                         push, push_last, push_end;

   // Handshake toward the sequencer.
   assign push_ok      = !out_vld_ff || rsp_ready;
   assign pack_full    = (pack_cnt_ff == FULL_CNT);
   assign flush_need   = !muted_ff && ((pack_cnt_ff != 4'd0) || ctl.stream_last);
   assign sts.byte_ok  = muted_ff || !pack_full || push_ok;
   assign sts.flush_ok = !flush_need || push_ok;
   assign do_emit      = ctl.emit && sts.byte_ok;
   assign do_flush     = ctl.flush && sts.flush_ok;

   // Packing: a full word leaves only when another byte arrives or the step ends,
   // so the word knows whether it is the last one of its step.
   always_comb begin
      pack_in     = pack_ff;
      pack_cnt_in = pack_cnt_ff;
      res_cnt_in  = res_cnt_ff;
      muted_in    = muted_ff;
      push        = 1'b0;
      push_last   = 1'b0;
      push_end    = 1'b0;
      if (do_flush) begin
         push        = flush_need;
         push_last   = 1'b1;
         push_end    = ctl.stream_last;
         pack_in     = '0;
         pack_cnt_in = 4'd0;
         res_cnt_in  = '0;
         muted_in    = 1'b0;
      end else if (do_emit && !muted_ff) begin
         if (pack_full) begin
            push       = 1'b1;
            push_last  = (res_cnt_ff == LAST_RES);
            push_end   = push_last && ctl.stream_last;
            res_cnt_in = res_cnt_ff + lzrle_pkg::RES_W'(1);
            if (push_last) begin
               // Result limit reached: later bytes of this step go to history only.
               muted_in    = 1'b1;
               pack_in     = '0;
               pack_cnt_in = 4'd0;
            end else begin
               pack_in     = {56'd0, ctl.data};
               pack_cnt_in = 4'd1;
            end
         end else begin
            pack_in[{pack_cnt_ff[2:0], 3'b000} +: 8] = ctl.data;
            pack_cnt_in = pack_cnt_ff + 4'd1;
         end
      end
   end

   // Result register valid flag.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (push) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff     <= '0;
         pack_cnt_ff <= 4'd0;
         res_cnt_ff  <= '0;
         muted_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pack_ff     <= pack_in;
         pack_cnt_ff <= pack_cnt_in;
         res_cnt_ff  <= res_cnt_in;
         muted_ff    <= muted_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Result word payload.
   always_ff @(posedge clock) begin
      if (push) begin
         out_bytes_ff <= pack_ff;
         out_cnt_ff   <= pack_cnt_ff;
         out_last_ff  <= push_last;
         out_end_ff   <= push_end;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_bytes  = out_bytes_ff;
   assign rsp_byte_count = out_cnt_ff;
   assign rsp_token_last = out_last_ff;
   assign rsp_stream_end = out_end_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for lz_rle_decompressor_core: directed token table, then random streams.
// Depends on lzrle_pkg (token codes, header length, result limit) and the core itself.
`timescale 1ns / 100ps

module testbench;

   localparam int LANES       = 8;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int RAND_WORDS  = 70;

   // One decoded result word as it leaves the core.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        tok_last;
      logic        str_end;
   } decoded_word_type;

   // One row of directed stimulus; typed rows carry their result word.
   typedef struct packed {
      logic [7:0]       in_byte;
      logic             is_last;
      logic             typed;
      decoded_word_type result;
   } stim_row_type;

   localparam decoded_word_type NO_WORD  = '0;
   localparam decoded_word_type END_MARK = '{64'h0, 4'd0, 1'b1, 1'b1};

   // Short stream, empty stream, then a stream of size 8 with every token kind,
   // a zero offset copy, and a run opener cut off by the final word.
   localparam stim_row_type DIRECTED [26] = '{
      '{8'hAB,               1'b1, 1'b1, END_MARK},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{lzrle_pkg::TOK_COPY, 1'b1, 1'b1, END_MARK},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h08,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b1, '{64'h00, 4'd1, 1'b1, 1'b0}},
      '{lzrle_pkg::TOK_ESC,  1'b0, 1'b0, NO_WORD},
      '{8'hFF,               1'b0, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0}},
      '{lzrle_pkg::TOK_COPY, 1'b0, 1'b0, NO_WORD},
      '{8'h03,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h01,               1'b0, 1'b0, NO_WORD},
      '{lzrle_pkg::TOK_COPY, 1'b0, 1'b0, NO_WORD},
      '{8'h02,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{8'h00,               1'b0, 1'b0, NO_WORD},
      '{lzrle_pkg::TOK_RUN,  1'b0, 1'b0, NO_WORD},
      '{8'h02,               1'b0, 1'b0, NO_WORD},
      '{8'h7E,               1'b0, 1'b0, NO_WORD},
      '{lzrle_pkg::TOK_RUN,  1'b0, 1'b0, NO_WORD},
      '{8'h05,               1'b1, 1'b0, NO_WORD}
   };

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte   = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_byte_count;
   logic        rsp_token_last;
   logic        rsp_stream_end;

   // Decoder state mirrored by the testbench.
   logic [7:0]  hist_mem [0:65535];
   logic [31:0] out_total   = '0;
   logic [31:0] size_target = '0;
   int          hdr_seen    = 0;
   logic [23:0] pend_bytes  = '0;
   int          pend_cnt    = 0;
   logic [7:0]  step_buf [$];

   // Result words still owed by the core, oldest first.
   decoded_word_type decoded_q [$];

   int fail_count    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int max_burst     = 0;
   int burst_left    = 0;
   int cycle_count   = 0;

   lz_rle_decompressor_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_token_last (rsp_token_last),
      .rsp_stream_end (rsp_stream_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Write one decoded byte into the history and the current step's output.
   function automatic void emit_byte(input logic [7:0] v);
      hist_mem[out_total[15:0]] = v;
      out_total++;
      step_buf.insert(step_buf.size(), v);
   endfunction

   // Decode one compressed word and queue the result words it causes.
   // Returns 1 when the word was not simply dropped.
   function automatic bit predict_word(input logic [7:0] b, input logic is_last);
      logic [7:0]       tok [4];
      logic [7:0]       t;
      logic [31:0]      src;
      decoded_word_type w;
      int               n, pos, need, span, nres;
      bit               used;
      used = is_last || (hdr_seen < lzrle_pkg::HDR_BYTES) || (out_total < size_target);
      step_buf.delete();
      if (hdr_seen < lzrle_pkg::HDR_BYTES) begin
         size_target = {size_target[23:0], b};
         hdr_seen++;
      end else if (out_total < size_target) begin
         n = pend_cnt;
         for (int i = 0; i < n; i++) tok[i] = pend_bytes[8*i +: 8];
         tok[n] = b;
         n++;
         pos = 0;
         while (pos < n && out_total < size_target) begin
            t = tok[pos];
            case (t)
               lzrle_pkg::TOK_COPY: need = 4;
               lzrle_pkg::TOK_RUN:  need = 3;
               lzrle_pkg::TOK_ESC:  need = 2;
               default:             need = 1;
            endcase
            if (n - pos >= need) begin
               case (t)
                  lzrle_pkg::TOK_COPY: begin
                     span = tok[pos+1];
                     src  = {tok[pos+2], tok[pos+3]};
                     // A zero offset or one reaching before the stream start copies nothing.
                     if (src != 0 && src <= out_total) begin
                        src = out_total - src;
                        for (int j = 0; j < span && out_total < size_target; j++)
                           emit_byte(hist_mem[16'(src + j)]);
                     end
                  end
                  lzrle_pkg::TOK_RUN: begin
                     for (int j = 0; j < int'(tok[pos+1]) && out_total < size_target; j++)
                        emit_byte(tok[pos+2]);
                  end
                  lzrle_pkg::TOK_ESC: emit_byte(tok[pos+1]);
                  default: emit_byte(t);
               endcase
               pos += need;
            end else if (is_last) begin
               // A token cut off by the end of the stream: its opener becomes a literal.
               emit_byte(t);
               pos++;
            end else begin
               break;
            end
         end
         pend_bytes = '0;
         pend_cnt   = 0;
         if (!is_last && pos < n && out_total < size_target) begin
            for (int i = pos; i < n; i++) pend_bytes[8*(i-pos) +: 8] = tok[i];
            pend_cnt = n - pos;
         end
      end

      // Pack the step's bytes, first byte in the lowest lane.
      nres = (step_buf.size() + LANES - 1) / LANES;
      if (nres > lzrle_pkg::MAX_RESULTS) nres = lzrle_pkg::MAX_RESULTS;
      if (nres == 0 && is_last) decoded_q.insert(decoded_q.size(), END_MARK);
      for (int k = 0; k < nres; k++) begin
         w = '0;
         for (int i = 0; i < LANES && k * LANES + i < step_buf.size(); i++) begin
            w.data[8*i +: 8] = step_buf[k * LANES + i];
            w.count = w.count + 4'd1;
         end
         w.tok_last = (k == nres - 1);
         w.str_end  = is_last && (k == nres - 1);
         decoded_q.insert(decoded_q.size(), w);
      end
      if (nres > max_burst) max_burst = nres;

      // The final word of a stream resets the stream state.
      if (is_last) begin
         out_total   = '0;
         size_target = '0;
         hdr_seen    = 0;
         pend_bytes  = '0;
         pend_cnt    = 0;
      end
      return used;
   endfunction

   // Length of a run or copy: mostly short, now and then up to the full byte.
   function automatic int pick_span();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, 12);
   endfunction

   // Offer one compressed word in bursts with random gaps; predict once it is taken.
   task automatic send_word(input stim_row_type row, output bit used);
      int gap, n0;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_in_byte   <= row.in_byte;
      req_last_byte <= row.is_last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      n0   = decoded_q.size();
      used = predict_word(row.in_byte, row.is_last);
      // Typed rows replace the computed words with the one written in the table.
      if (row.typed) begin
         while (decoded_q.size() > n0) void'(decoded_q.pop_back());
         decoded_q.insert(decoded_q.size(), row.result);
      end
      words_sent++;
   endtask

   // Stimulus: reset, directed table, random streams, drain.
   initial begin : stimulus
      logic [7:0]   stream_q [$];
      logic [7:0]   body [$];
      logic [7:0]   opener;
      logic [31:0]  hdr_size;
      stim_row_type row;
      bit           used;
      int           gen_len, span, off, extra, rand_used, n_streams;

      rand_used = 0;
      n_streams = 3;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_word(DIRECTED[i], used);

      while (rand_used < RAND_WORDS) begin
         stream_q.delete();
         if ($urandom_range(0, 7) == 0) begin
            // Noise: random bytes, header included, often cut off inside the header.
            repeat ($urandom_range(1, 10)) stream_q.insert(stream_q.size(), 8'($urandom));
         end else begin
            body.delete();
            gen_len = 0;
            repeat ($urandom_range(1, 10)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: begin
                     body.insert(body.size(), 8'($urandom_range(0, 8'hFC)));
                     gen_len++;
                  end
                  4: begin
                     body.insert(body.size(), lzrle_pkg::TOK_ESC);
                     body.insert(body.size(), 8'($urandom));
                     gen_len++;
                  end
                  5, 6: begin
                     span = pick_span();
                     body.insert(body.size(), lzrle_pkg::TOK_RUN);
                     body.insert(body.size(), 8'(span));
                     body.insert(body.size(), 8'($urandom));
                     gen_len += span;
                  end
                  default: begin
                     span = pick_span();
                     // Mostly a valid offset; otherwise anything, zero and too far included.
                     if (gen_len > 0 && $urandom_range(0, 7) != 0) begin
                        off = $urandom_range(1, gen_len);
                        gen_len += span;
                     end else begin
                        off = $urandom_range(0, 65535);
                     end
                     body.insert(body.size(), lzrle_pkg::TOK_COPY);
                     body.insert(body.size(), 8'(span));
                     body.insert(body.size(), 8'(off >> 8));
                     body.insert(body.size(), 8'(off));
                  end
               endcase
            end
            // Sometimes the stream ends inside a token.
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     opener = lzrle_pkg::TOK_COPY;
                     extra  = $urandom_range(0, 2);
                  end
                  1: begin
                     opener = lzrle_pkg::TOK_RUN;
                     extra  = $urandom_range(0, 1);
                  end
                  default: begin
                     opener = lzrle_pkg::TOK_ESC;
                     extra  = 0;
                  end
               endcase
               body.insert(body.size(), opener);
               repeat (extra) body.insert(body.size(), 8'($urandom));
               gen_len += 1 + extra;
            end
            case ($urandom_range(0, 9))
               0:       hdr_size = '0;
               1, 2:    hdr_size = $urandom_range(0, gen_len);
               3:       hdr_size = gen_len + $urandom_range(1, 300);
               4:       hdr_size = $urandom;
               default: hdr_size = gen_len;
            endcase
            stream_q = {hdr_size[31:24], hdr_size[23:16], hdr_size[15:8], hdr_size[7:0]};
            foreach (body[i]) stream_q.insert(stream_q.size(), body[i]);
         end
         foreach (stream_q[i]) begin
            row = '{stream_q[i], i == stream_q.size() - 1, 1'b0, NO_WORD};
            send_word(row, used);
            if (used) rand_used++;
         end
         n_streams++;
      end
      req_valid <= 1'b0;

      // Drain, then give a long copy time to show any stray word.
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Decoded %0d streams from %0d compressed words, checking %0d result words.",
               n_streams, words_sent, words_checked);
      $display("Largest expansion was %0d result words from one compressed word.", max_burst);
      if (fail_count == 0) begin
         $display("** lz_rle_decompressor_core: PASSED **");
      end else begin
         $display("** lz_rle_decompressor_core: FAILED **");
      end
      $finish;
   end

   // Result side: stall patterns that change now and then, plus one long hold-off
   // that lets the core fill up and push back on its input.
   initial begin : rsp_side
      int mode, mode_left, hold_left, phase;
      bit held;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         phase = (phase + 1) % 3;
         if (!held && words_checked >= 30) begin
            held      = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= (phase != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Compare each accepted result word with the oldest one owed.
   always @(posedge clock) begin : rsp_check
      decoded_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (decoded_q.size() == 0) begin
            $error("unexpected result word: out_bytes %h byte_count %0d",
                   rsp_out_bytes, rsp_byte_count);
            fail_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_bytes !== want.data) begin
               $error("out_bytes: expected %h, got %h", want.data, rsp_out_bytes);
               fail_count++;
            end
            if (rsp_byte_count !== want.count) begin
               $error("byte_count: expected %0d, got %0d", want.count, rsp_byte_count);
               fail_count++;
            end
            if (rsp_token_last !== want.tok_last) begin
               $error("token_last: expected %b, got %b", want.tok_last, rsp_token_last);
               fail_count++;
            end
            if (rsp_stream_end !== want.str_end) begin
               $error("stream_end: expected %b, got %b", want.str_end, rsp_stream_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** lz_rle_decompressor_core: FAILED **");
         $finish;
      end
   end

endmodule

// ===== lz_rle_decompressor_core.f =====
sv/lzrle_pkg.sv
sv/lzrle_hist_ram.sv
sv/lzrle_out_pack.sv
sv/lz_rle_decompressor_core.sv
test/testbench.sv
